>>> hdl/rbbe_pkg.sv
package rbbe_pkg;

   // default build values
   localparam int SCREEN_WIDTH_DEF   = 320;
   localparam int VRAM_ADDR_BITS_DEF = 17;

   // fixed field widths
   localparam int COORD_W     = 10;
   localparam int BYTE_W      = 8;
   localparam int VRAM_ADDR_W = 17;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 10;

   // job queue between front and back
   localparam int JOBQ_DEPTH  = 4;

   localparam logic [BYTE_W-1:0] PIXEL_ON  = 8'hFF;
   localparam logic [BYTE_W-1:0] PIXEL_OFF = 8'h00;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEST_X      = 3'd0,
      CSR_DEST_Y      = 3'd1,
      CSR_RECT_WIDTH  = 3'd2,
      CSR_RECT_HEIGHT = 3'd3,
      CSR_BIT_MODE    = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] src_byte;
   } req_type;

   typedef struct packed {
      logic [VRAM_ADDR_W-1:0] vram_addr;
      logic [BYTE_W-1:0]      pixel;
      logic                   write_valid;
      logic                   last;
   } rsp_type;

   // one classified word for the back end: 1 or 8 writes, or the empty marker
   typedef struct packed {
      logic [VRAM_ADDR_W-1:0] base_addr;
      logic [BYTE_W-1:0]      src_byte;
      logic                   bit_mode;
      logic                   write_valid;
      logic                   last;
   } job_type;

endpackage

>>> hdl/rect_blitter_bit_expand_top.sv
// an accepted word is queued, then its first result word goes to the output register
// throughput: one source word per cycle in byte mode unless the output stalls;
//    in bit mode each source word expands to eight pixel writes, one per cycle
// a four-entry job queue lets the front keep accepting words while the back expands
// reset: synchronous, active high; clears registers, transfer state, queue and output
module rect_blitter_bit_expand_top #(
   parameter int SCREEN_WIDTH   = rbbe_pkg::SCREEN_WIDTH_DEF,
   parameter int VRAM_ADDR_BITS = rbbe_pkg::VRAM_ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rbbe_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rbbe_pkg::rsp_type               rsp_data,
   // register write port
   input  logic                            csr_we,
   input  logic [rbbe_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rbbe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rbbe_pkg::*;

   // front to queue
   logic    job_push;
   job_type job_data;
   logic    job_full;
   // queue to back
   logic    job_pop;
   job_type job_head;
   logic    job_empty;

   // front: register file, transfer position tracking, address of each word
   rbbe_front #(
      .SCREEN_WIDTH   (SCREEN_WIDTH),
      .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job_data  (job_data),
      .job_full  (job_full)
   );

   // short queue decoupling word intake from pixel output
   rbbe_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   // back: one pixel write per cycle into the output register, unless stalled
   rbbe_back #(
      .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_head  (job_head),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/rbbe_front.sv
module rbbe_front #(
   parameter int SCREEN_WIDTH   = rbbe_pkg::SCREEN_WIDTH_DEF,
   parameter int VRAM_ADDR_BITS = rbbe_pkg::VRAM_ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rbbe_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [rbbe_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rbbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                job_push,
   output rbbe_pkg::job_type                   job_data,
   input  logic                                job_full
);
   import rbbe_pkg::*;

   localparam int AW = VRAM_ADDR_BITS;

   // configuration registers
   logic [COORD_W-1:0] dest_x_ff, dest_y_ff, width_ff, height_cfg_ff;
   logic               bit_mode_cfg_ff;

   // transfer state
   logic               busy_ff, busy_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [COORD_W-1:0] bpr_ff, bpr_in, height_ff, height_in;
   logic               mode_ff, mode_in;
   logic [AW-1:0]      base_ff, base_in;

   logic               accept;
   logic               row_end, final_word;
   logic [AW-1:0]      start_base, col_off, word_addr;
   logic [COORD_W-1:0] start_bpr;

   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;

   assign start_base = AW'(dest_y_ff) * AW'(SCREEN_WIDTH) + AW'(dest_x_ff);
   assign start_bpr  = bit_mode_cfg_ff ? {3'b000, width_ff[COORD_W-1:3]} : width_ff;

   assign row_end    = ({1'b0, col_ff} + 11'd1) >= {1'b0, bpr_ff};
   assign final_word = row_end && (({1'b0, row_ff} + 11'd1) >= {1'b0, height_ff});
   assign col_off    = mode_ff ? AW'({col_ff, 3'b000}) : AW'(col_ff);
   assign word_addr  = base_ff + col_off;

   always_comb begin
      busy_in   = busy_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      bpr_in    = bpr_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      base_in   = base_ff;
      job_push  = 1'b0;
      job_data  = '0;
      if (accept) begin
         if (req_data.opcode == OP_START) begin
            mode_in   = bit_mode_cfg_ff;
            bpr_in    = start_bpr;
            height_in = height_cfg_ff;
            row_in    = '0;
            col_in    = '0;
            base_in   = start_base;
            if (height_cfg_ff == '0 || start_bpr == '0) begin
               // empty rectangle: single marker word
               busy_in              = 1'b0;
               job_push             = 1'b1;
               job_data.write_valid = 1'b0;
               job_data.last        = 1'b1;
            end else begin
               busy_in = 1'b1;
            end
         end else if (busy_ff) begin
            job_push             = 1'b1;
            job_data.base_addr   = VRAM_ADDR_W'(word_addr);
            job_data.src_byte    = req_data.src_byte;
            job_data.bit_mode    = mode_ff;
            job_data.write_valid = 1'b1;
            job_data.last        = final_word;
            if (row_end) begin
               col_in  = '0;
               row_in  = row_ff + 10'd1;
               base_in = base_ff + AW'(SCREEN_WIDTH);
               if (final_word) begin
                  busy_in = 1'b0;
               end
            end else begin
               col_in = col_ff + 10'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
         width_ff        <= '0;
         height_cfg_ff   <= '0;
         bit_mode_cfg_ff <= 1'b0;
         busy_ff         <= 1'b0;
         row_ff          <= '0;
         col_ff          <= '0;
         bpr_ff          <= '0;
         height_ff       <= '0;
         mode_ff         <= 1'b0;
         base_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEST_X:      dest_x_ff       <= csr_wdata;
               CSR_DEST_Y:      dest_y_ff       <= csr_wdata;
               CSR_RECT_WIDTH:  width_ff        <= csr_wdata;
               CSR_RECT_HEIGHT: height_cfg_ff   <= csr_wdata;
               CSR_BIT_MODE:    bit_mode_cfg_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         busy_ff   <= busy_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         bpr_ff    <= bpr_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         base_ff   <= base_in;
      end
   end

   a_busy_dims: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bpr_ff != '0 && height_ff != '0))
      else $error("busy with an empty rectangle");

   a_busy_pos: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_ff < height_ff && col_ff < bpr_ff))
      else $error("position outside the rectangle");

endmodule

>>> hdl/rbbe_jobq.sv
module rbbe_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbbe_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output rbbe_pkg::job_type head,
   output logic              empty
);
   import rbbe_pkg::*;

   localparam int PW = $clog2(JOBQ_DEPTH);
   localparam int CW = $clog2(JOBQ_DEPTH + 1);

   job_type         mem_ff [JOBQ_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = count_ff == CW'(JOBQ_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(JOBQ_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(JOBQ_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(JOBQ_DEPTH))
      else $error("job queue count overflow");

endmodule

>>> hdl/rbbe_back.sv
module rbbe_back #(
   parameter int VRAM_ADDR_BITS = rbbe_pkg::VRAM_ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rbbe_pkg::job_type job_head,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rbbe_pkg::rsp_type rsp_data
);
   import rbbe_pkg::*;

   localparam int AW = VRAM_ADDR_BITS;

   logic          active_ff, active_in;
   logic [2:0]    cnt_ff, cnt_in;
   job_type       job_ff, job_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          out_free;
   job_type       cur_job;
   logic [2:0]    cur_idx;
   logic          emit;
   logic [AW-1:0] pix_addr;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign job_pop  = out_free && !active_ff && !job_empty;
   assign emit     = out_free && (active_ff || !job_empty);
   assign cur_job  = active_ff ? job_ff : job_head;
   assign cur_idx  = active_ff ? cnt_ff : 3'd0;
   assign pix_addr = AW'(cur_job.base_addr) + AW'(cur_idx);

   always_comb begin
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_in.vram_addr   = VRAM_ADDR_W'(pix_addr);
            rsp_in.write_valid = cur_job.write_valid;
            if (cur_job.bit_mode) begin
               // msb first
               rsp_in.pixel = cur_job.src_byte[~cur_idx] ? PIXEL_ON : PIXEL_OFF;
               rsp_in.last  = cur_job.last && (cur_idx == 3'd7);
            end else begin
               rsp_in.pixel = cur_job.src_byte;
               rsp_in.last  = cur_job.last;
            end
            if (active_ff) begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  active_in = 1'b0;
               end
            end else if (job_head.bit_mode) begin
               active_in = 1'b1;
               cnt_in    = 3'd1;
               job_in    = job_head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_active_job: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff != 3'd0 && job_ff.bit_mode))
      else $error("expansion active without a bit-mode job");

   a_no_pop_mid: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !job_pop)
      else $error("job popped during expansion");

endmodule
